// ----- design/ansi_key_escape_decoder_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef ANSI_KEY_ESCAPE_DECODER_ASSERT_SVH
`define ANSI_KEY_ESCAPE_DECODER_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define AKD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, during reset too.
`define AKD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/akd_pkg.sv -----
`default_nettype none

package akd_pkg;

    localparam logic [7:0] ESC_BYTE  = 8'd27;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_6      = 8'h36;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam int PEND_W = 5;

    localparam logic [7:0] K_UNKNOWN = 8'd0;
    localparam logic [7:0] K_UP      = 8'd1;
    localparam logic [7:0] K_HOME    = 8'd5;
    localparam logic [7:0] K_INSERT  = 8'd6;
    localparam logic [7:0] K_DELETE  = 8'd7;
    localparam logic [7:0] K_F1      = 8'd11;
    localparam logic [7:0] K_F6      = 8'd16;
    localparam logic [7:0] K_F9      = 8'd19;
    localparam logic [7:0] K_F10     = 8'd20;
    localparam logic [7:0] K_F12     = 8'd21;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ESC   = 7'b0000010,
        ST_CSI   = 7'b0000100,
        ST_D1    = 7'b0001000,
        ST_D2    = 7'b0010000,
        ST_CSI2  = 7'b0100000,
        ST_TILDE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       emit;
        logic       special;
        logic [7:0] code;
    } dec_t;

endpackage

`default_nettype wire

// ----- design/akd_decode.sv -----
`default_nettype none

module akd_decode (
    input  akd_pkg::state_t                 state,
    input  logic [akd_pkg::PEND_W-1:0]      pend,
    input  logic [7:0]                      rx_byte,
    output akd_pkg::state_t                 state_next,
    output logic [akd_pkg::PEND_W-1:0]      pend_next,
    output akd_pkg::dec_t                   dec
);
    import akd_pkg::*;

    logic [7:0] off_a;
    logic [7:0] off_3;
    logic [7:0] off_7;

    assign off_a = rx_byte - CH_A;
    assign off_3 = rx_byte - CH_3;
    assign off_7 = rx_byte - CH_7;

    always_comb
    begin
        state_next  = state;
        pend_next   = pend;
        dec.emit    = 1'b1;
        dec.special = 1'b1;
        dec.code    = K_UNKNOWN;
        unique case (state)
            ST_IDLE:
            begin
                if (rx_byte == ESC_BYTE)
                begin
                    state_next = ST_ESC;
                    dec.emit   = 1'b0;
                end
                else
                begin
                    dec.special = 1'b0;
                    dec.code    = rx_byte;
                end
            end
            ST_ESC:
            begin
                if (rx_byte == CH_LBRACK)
                begin
                    state_next = ST_CSI;
                    dec.emit   = 1'b0;
                end
            end
            ST_CSI:
            begin
                priority if (rx_byte >= CH_A && rx_byte <= CH_D)
                begin
                    dec.code = K_UP + off_a;
                end
                else if (rx_byte == CH_1)
                begin
                    state_next = ST_D1;
                    dec.emit   = 1'b0;
                end
                else if (rx_byte == CH_2)
                begin
                    state_next = ST_D2;
                    dec.emit   = 1'b0;
                end
                else if (rx_byte >= CH_3 && rx_byte <= CH_6)
                begin
                    state_next = ST_TILDE;
                    pend_next  = PEND_W'(K_DELETE + off_3);
                    dec.emit   = 1'b0;
                end
                else if (rx_byte == CH_LBRACK)
                begin
                    state_next = ST_CSI2;
                    dec.emit   = 1'b0;
                end
                else
                begin
                    dec.code = K_UNKNOWN;
                end
            end
            ST_D1:
            begin
                priority if (rx_byte == CH_TILDE)
                begin
                    dec.code = K_HOME;
                end
                else if (rx_byte >= CH_7 && rx_byte <= CH_9)
                begin
                    state_next = ST_TILDE;
                    pend_next  = PEND_W'(K_F6 + off_7);
                    dec.emit   = 1'b0;
                end
                else
                begin
                    dec.code = K_UNKNOWN;
                end
            end
            ST_D2:
            begin
                priority if (rx_byte == CH_TILDE)
                begin
                    dec.code = K_INSERT;
                end
                else if (rx_byte == CH_0 || rx_byte == CH_1 || rx_byte == CH_4)
                begin
                    state_next = ST_TILDE;
                    dec.emit   = 1'b0;
                    priority if (rx_byte == CH_0)
                    begin
                        pend_next = PEND_W'(K_F9);
                    end
                    else if (rx_byte == CH_1)
                    begin
                        pend_next = PEND_W'(K_F10);
                    end
                    else
                    begin
                        pend_next = PEND_W'(K_F12);
                    end
                end
                else
                begin
                    dec.code = K_UNKNOWN;
                end
            end
            ST_CSI2:
            begin
                if (rx_byte >= CH_A && rx_byte <= CH_E)
                begin
                    dec.code = K_F1 + off_a;
                end
            end
            ST_TILDE:
            begin
                if (rx_byte == CH_TILDE)
                begin
                    dec.code = {{(8 - PEND_W){1'b0}}, pend};
                end
            end
            default:
            begin
                dec.code = K_UNKNOWN;
            end
        endcase
        if (dec.emit)
        begin
            state_next = ST_IDLE;
        end
    end

endmodule

`default_nettype wire

// ----- design/ansi_key_escape_decoder.sv -----
// ANSI key escape decoder.
// The rx channel (rx_valid, rx_stall, rx_byte) takes one terminal byte per beat.
// The key channel (key_valid, key_stall, is_special, key_code) gives one key per
// finished sequence or plain byte; bytes inside an escape sequence give no beat.
// A beat moves at a rising edge where valid is high and stall is low.
// A byte is held in an input register, decoded combinationally against the parse
// state, and its key is registered in the output register, from which key_valid
// rises; a stall on the output can hold the byte in the input register between.
// One byte per cycle is accepted while key_stall does not hold the output
// register; the parse state and pending-code registers feed back through the decoder.
// When key_stall holds the output register, a byte that yields a key waits in
// the input register and rx_stall rises; bytes that only advance the sequence
// still pass. Reset (rst_n low, asynchronous) returns the parser to idle and
// drops any byte or key in flight.
`default_nettype none

module ansi_key_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       key_valid,
    input  logic       key_stall,
    output logic       is_special,
    output logic [7:0] key_code
);
    import akd_pkg::*;

    logic                rx_vld_reg;
    logic                rx_vld_next;
    logic [7:0]          rx_byte_reg;
    state_t              state_reg;
    state_t              state_next;
    logic [PEND_W-1:0]   pend_reg;
    logic [PEND_W-1:0]   pend_next;
    logic                key_vld_reg;
    logic                key_vld_next;
    logic                is_special_reg;
    logic [7:0]          key_code_reg;
    dec_t                dec;
    logic                out_free;
    logic                advance;
    logic                rx_take;
    logic                load_key;
    logic                idle_plain;
    logic                idle_esc;
    logic                key_special;
    logic                plain_out;

    akd_decode u_decode (
        .state      (state_reg),
        .pend       (pend_reg),
        .rx_byte    (rx_byte_reg),
        .state_next (state_next),
        .pend_next  (pend_next),
        .dec        (dec)
    );

    assign out_free     = !key_vld_reg || !key_stall;
    assign advance      = rx_vld_reg && (!dec.emit || out_free);
    assign rx_stall     = rx_vld_reg && !advance;
    assign rx_take      = rx_valid && !rx_stall;
    assign load_key     = advance && dec.emit;
    assign rx_vld_next  = rx_take || (rx_vld_reg && !advance);
    assign key_vld_next = load_key || (key_vld_reg && key_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_vld_reg  <= 1'b0;
            key_vld_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
        end
        else
        begin
            rx_vld_reg  <= rx_vld_next;
            key_vld_reg <= key_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
                pend_reg  <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            rx_byte_reg <= rx_byte;
        end
        if (load_key)
        begin
            is_special_reg <= dec.special;
            key_code_reg   <= dec.code;
        end
    end

    assign key_valid  = key_vld_reg;
    assign is_special = is_special_reg;
    assign key_code   = key_code_reg;

    assign idle_plain  = advance && state_reg == ST_IDLE && rx_byte_reg != ESC_BYTE;
    assign idle_esc    = advance && state_reg == ST_IDLE && rx_byte_reg == ESC_BYTE;
    assign key_special = key_vld_reg && is_special_reg;
    assign plain_out   = key_vld_reg && !is_special_reg;

`include "ansi_key_escape_decoder_assert.svh"

    `AKD_ASSERT(a_key_ends_seq, load_key |=> state_reg == ST_IDLE, "parser not idle after a key")
    `AKD_ASSERT(a_special_range, key_special |-> key_code_reg <= K_F12, "special code too large")
    `AKD_ASSERT(a_plain_kind, idle_plain |=> plain_out, "plain byte gave no plain key")
    `AKD_ASSERT(a_plain_code, idle_plain |=> key_code_reg == $past(rx_byte_reg), "bad plain code")
    `AKD_ASSERT(a_esc_silent, idle_esc |-> !dec.emit, "ESC gave a key")
    `AKD_ASSERT_ALWAYS(a_stall_needs_byte, rx_stall |-> rx_vld_reg, "stall without a held byte")

endmodule

`default_nettype wire
